>>> sv/fmp_pkg.sv
// ----------------------------------------------------------------------------
// fmp_pkg
// Types and constants shared by the metadata parser modules.
// ----------------------------------------------------------------------------
package fmp_pkg;

   localparam logic [31:0] FLAC_SIG = 32'h664c6143;

   localparam logic [3:0] EV_HEADER   = 4'd0;
   localparam logic [3:0] EV_SINFO    = 4'd1;
   localparam logic [3:0] EV_VLEN     = 4'd2;
   localparam logic [3:0] EV_VBYTE    = 4'd3;
   localparam logic [3:0] EV_CCOUNT   = 4'd4;
   localparam logic [3:0] EV_CLEN     = 4'd5;
   localparam logic [3:0] EV_CBYTE    = 4'd6;
   localparam logic [3:0] EV_BADSIG   = 4'd7;
   localparam logic [3:0] EV_END      = 4'd8;

   localparam logic [6:0] TYPE_SINFO  = 7'd0;
   localparam logic [6:0] TYPE_VORBIS = 7'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic [3:0]  event_res;
      logic [6:0]  block_type;
      logic        is_last_block;
      logic [3:0]  field_index;
      logic [31:0] item_index;
      logic [35:0] value;
      logic        last_of_run;
   } rsp_type;

   // one parsed byte: up to three results
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
      rsp_type    r2;
   } group_type;

endpackage

>>> sv/fmp_front.sv
// ----------------------------------------------------------------------------
// fmp_front
// Byte parser: tracks the metadata structure and produces result groups.
// ----------------------------------------------------------------------------
module fmp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  fmp_pkg::req_type   in_req,
   output logic               in_stall,
   output logic               grp_valid,
   output fmp_pkg::group_type grp_data,
   input  logic               grp_full
);

   typedef enum logic [3:0] {
      PH_SIG, PH_HDR, PH_SI, PH_VLEN, PH_VSTR, PH_CCOUNT, PH_CLEN, PH_CSTR,
      PH_SKIP, PH_IDLE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] gath_ff, gath_in;
   logic [6:0]  type_ff, type_in;
   logic        last_ff, last_in;
   logic [23:0] body_ff, body_in;
   logic [31:0] crem_ff, crem_in;
   logic [31:0] cnum_ff, cnum_in;
   logic [31:0] srem_ff, srem_in;

   fmp_pkg::group_type grp;
   logic               acc;

   assign in_stall  = grp_full;
   assign acc       = in_valid && !grp_full;
   assign grp_valid = acc && (grp.count != 2'd0);
   assign grp_data  = grp;

   always_comb begin
      phase_type   ph;
      logic [5:0]  c;
      logic [63:0] g;
      logic [31:0] le;
      logic        ended;
      logic [7:0]  b;
      fmp_pkg::rsp_type rs [3];

      phase_in = phase_ff; cnt_in = cnt_ff; gath_in = gath_ff;
      type_in = type_ff; last_in = last_ff; body_in = body_ff;
      crem_in = crem_ff; cnum_in = cnum_ff; srem_in = srem_ff;
      b = in_req.data_byte;
      for (int i = 0; i < 3; i++) rs[i] = '0;
      grp = '0;
      ended = 1'b0;
      le = '0;
      g = '0;
      c = '0;

      if (in_req.start_of_file) begin
         phase_in = PH_SIG; cnt_in = '0; gath_in = '0; type_in = '0;
         last_in = 1'b0; body_in = '0; crem_in = '0; cnum_in = '0; srem_in = '0;
      end
      ph = phase_in;

      // grp.count acts as emit pointer; fields use current type/last at emit
      case (ph)
         PH_SIG, PH_HDR: begin
            g = {32'd0, gath_in[23:0], b};
            c = cnt_in + 6'd1;
            gath_in = g;
            cnt_in = c;
            if (c >= 6'd4) begin
               if (ph == PH_SIG) begin
                  if (g[31:0] != fmp_pkg::FLAC_SIG) begin
                     rs[0].event_res = fmp_pkg::EV_BADSIG;
                     rs[0].block_type = type_in;
                     rs[0].is_last_block = last_in;
                     grp.count = 2'd1;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_HDR; cnt_in = '0; gath_in = '0;
                  end
               end else begin
                  last_in = g[31];
                  type_in = g[30:24];
                  body_in = g[23:0];
                  rs[0].event_res = fmp_pkg::EV_HEADER;
                  rs[0].block_type = g[30:24];
                  rs[0].is_last_block = g[31];
                  rs[0].value = {12'd0, g[23:0]};
                  grp.count = 2'd1;
                  cnt_in = '0; gath_in = '0;
                  if (g[30:24] == fmp_pkg::TYPE_SINFO) phase_in = PH_SI;
                  else if (g[30:24] == fmp_pkg::TYPE_VORBIS) phase_in = PH_VLEN;
                  else phase_in = PH_SKIP;
                  ended = (g[23:0] == 24'd0);
               end
            end
         end
         PH_IDLE: begin
         end
         default: begin
            le = gath_in[31:0] | ({24'd0, b} << {cnt_in[1:0], 3'b000});
            case (ph)
               PH_SI: begin
                  g = {gath_in[55:0], b};
                  c = cnt_in + 6'd1;
                  gath_in = g; cnt_in = c;
                  grp.count = 2'd1;
                  rs[0].event_res = fmp_pkg::EV_SINFO;
                  rs[1].event_res = fmp_pkg::EV_SINFO;
                  case (c)
                     6'd2:  rs[0].value = {20'd0, g[15:0]};
                     6'd4: begin rs[0].field_index = 4'd1; rs[0].value = {20'd0, g[15:0]}; end
                     6'd7: begin rs[0].field_index = 4'd2; rs[0].value = {12'd0, g[23:0]}; end
                     6'd10: begin rs[0].field_index = 4'd3; rs[0].value = {12'd0, g[23:0]}; end
                     6'd13: begin
                        rs[0].field_index = 4'd4; rs[0].value = {16'd0, g[23:4]};
                        rs[1].field_index = 4'd5;
                        rs[1].value = {33'd0, g[3:1]} + 36'd1;
                        grp.count = 2'd2;
                     end
                     6'd14: begin
                        rs[0].field_index = 4'd6;
                        rs[0].value = {31'd0, g[8:4]} + 36'd1;
                     end
                     6'd18: begin rs[0].field_index = 4'd7; rs[0].value = g[35:0]; end
                     6'd22: begin rs[0].field_index = 4'd8; rs[0].value = {4'd0, g[31:0]}; end
                     6'd26: begin rs[0].field_index = 4'd9; rs[0].value = {4'd0, g[31:0]}; end
                     6'd30: begin rs[0].field_index = 4'd10; rs[0].value = {4'd0, g[31:0]}; end
                     6'd34: begin
                        rs[0].field_index = 4'd11; rs[0].value = {4'd0, g[31:0]};
                        phase_in = PH_SKIP;
                     end
                     default: grp.count = 2'd0;
                  endcase
               end
               PH_VLEN, PH_CCOUNT, PH_CLEN: begin
                  cnt_in = {4'd0, cnt_in[1:0] + 2'd1};
                  gath_in = {32'd0, le};
                  if (cnt_in[1:0] == 2'd0) begin
                     gath_in = '0;
                     grp.count = 2'd1;
                     rs[0].value = {4'd0, le};
                     if (ph == PH_VLEN) begin
                        srem_in = le;
                        rs[0].event_res = fmp_pkg::EV_VLEN;
                        phase_in = (le != 32'd0) ? PH_VSTR : PH_CCOUNT;
                     end else if (ph == PH_CCOUNT) begin
                        crem_in = le; cnum_in = '0;
                        rs[0].event_res = fmp_pkg::EV_CCOUNT;
                        phase_in = (le != 32'd0) ? PH_CLEN : PH_SKIP;
                     end else begin
                        srem_in = le;
                        rs[0].event_res = fmp_pkg::EV_CLEN;
                        rs[0].item_index = cnum_in;
                        if (le == 32'd0) begin
                           cnum_in = cnum_in + 32'd1;
                           crem_in = crem_in - 32'd1;
                           phase_in = (crem_in != 32'd0) ? PH_CLEN : PH_SKIP;
                        end else phase_in = PH_CSTR;
                     end
                  end
               end
               PH_VSTR: begin
                  rs[0].event_res = fmp_pkg::EV_VBYTE;
                  rs[0].value = {28'd0, b};
                  grp.count = 2'd1;
                  srem_in = srem_in - 32'd1;
                  if (srem_in == 32'd0) phase_in = PH_CCOUNT;
               end
               PH_CSTR: begin
                  rs[0].event_res = fmp_pkg::EV_CBYTE;
                  rs[0].item_index = cnum_in;
                  rs[0].value = {28'd0, b};
                  grp.count = 2'd1;
                  srem_in = srem_in - 32'd1;
                  if (srem_in == 32'd0) begin
                     cnum_in = cnum_in + 32'd1;
                     crem_in = crem_in - 32'd1;
                     phase_in = (crem_in != 32'd0) ? PH_CLEN : PH_SKIP;
                  end
               end
               default: begin
               end
            endcase
            for (int i = 0; i < 2; i++) begin
               rs[i].block_type = type_in;
               rs[i].is_last_block = last_in;
            end
            body_in = body_in - 24'd1;
            ended = (body_in == 24'd0);
         end
      endcase

      if (ended) begin
         if (last_in) begin
            rs[grp.count].event_res = fmp_pkg::EV_END;
            rs[grp.count].block_type = type_in;
            rs[grp.count].is_last_block = last_in;
            rs[grp.count].field_index = '0;
            rs[grp.count].item_index = '0;
            rs[grp.count].value = '0;
            grp.count = grp.count + 2'd1;
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_HDR; cnt_in = '0; gath_in = '0;
         end
      end
      if (grp.count != 2'd0) rs[grp.count - 2'd1].last_of_run = 1'b1;
      grp.r0 = rs[0]; grp.r1 = rs[1]; grp.r2 = rs[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIG; cnt_ff <= '0; gath_ff <= '0; type_ff <= '0;
         last_ff <= 1'b0; body_ff <= '0; crem_ff <= '0; cnum_ff <= '0;
         srem_ff <= '0;
      end else if (acc) begin
         phase_ff <= phase_in; cnt_ff <= cnt_in; gath_ff <= gath_in;
         type_ff <= type_in; last_ff <= last_in; body_ff <= body_in;
         crem_ff <= crem_in; cnum_ff <= cnum_in; srem_ff <= srem_in;
      end
   end

endmodule

>>> sv/fmp_queue.sv
// ----------------------------------------------------------------------------
// fmp_queue
// Two-entry queue of result groups between parser and output sequencer.
// ----------------------------------------------------------------------------
module fmp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   input  fmp_pkg::group_type wr_data,
   output logic               full,
   output logic               rd_valid,
   output fmp_pkg::group_type rd_data,
   input  logic               rd_pop
);

   fmp_pkg::group_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push;

   assign push     = wr_valid && (cnt_ff != 2'd2);
   assign full     = (cnt_ff == 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (rd_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, rd_pop};
      end
   end

endmodule

>>> sv/fmp_back.sv
// ----------------------------------------------------------------------------
// fmp_back
// Sends the results of each queued group one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module fmp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               grp_valid,
   input  fmp_pkg::group_type grp_data,
   output logic               grp_pop,
   output logic               out_valid,
   output fmp_pkg::rsp_type   out_rsp,
   input  logic               out_stall
);

   logic [1:0] sel_ff;
   logic       take;

   assign out_valid = grp_valid;
   assign take      = grp_valid && !out_stall;
   assign grp_pop   = take && (sel_ff == grp_data.count - 2'd1);

   always_comb begin
      case (sel_ff)
         2'd0:    out_rsp = grp_data.r0;
         2'd1:    out_rsp = grp_data.r1;
         default: out_rsp = grp_data.r2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) sel_ff <= '0;
      else if (grp_pop) sel_ff <= '0;
      else if (take) sel_ff <= sel_ff + 2'd1;
   end

endmodule

>>> sv/flac_metadata_parser.sv
// ----------------------------------------------------------------------------
// flac_metadata_parser
// Byte-wide FLAC metadata block parser.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    fmp_pkg::req_type
//   rsp      out  rsp_valid/stall    fmp_pkg::rsp_type
//
// One byte per cycle while req_stall is low; each byte's results (up to
// three) go into a two-group queue and leave one per cycle while
// rsp_stall is low, the group staying queued until its last result is sent.
// Synchronous reset returns the parser to the signature phase.
// req_stall rises only when the queue holds two groups.
// ----------------------------------------------------------------------------
module flac_metadata_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  fmp_pkg::req_type req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output fmp_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);

   logic               fv, qfull, qv, qpop;
   fmp_pkg::group_type fg, qg;

   fmp_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_req(req_data),
      .in_stall(req_stall), .grp_valid(fv), .grp_data(fg), .grp_full(qfull)
   );

   fmp_queue u_queue (
      .clock(clock), .reset(reset), .wr_valid(fv), .wr_data(fg), .full(qfull),
      .rd_valid(qv), .rd_data(qg), .rd_pop(qpop)
   );

   fmp_back u_back (
      .clock(clock), .reset(reset), .grp_valid(qv), .grp_data(qg),
      .grp_pop(qpop), .out_valid(rsp_valid), .out_rsp(rsp_data),
      .out_stall(rsp_stall)
   );

`ifndef SYNTH
   a_grp_nonempty: assert property (@(posedge clock) disable iff (reset)
      qv |-> (qg.count != 2'd0))
      else $error("empty group in queue");
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      qfull |-> req_stall)
      else $error("input taken while queue full");
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      qpop |-> rsp_data.last_of_run)
      else $error("group released before final result");
`endif

endmodule

>>> verif/fmp_checker.sv
// ----------------------------------------------------------------------------
// fmp_checker
// Watches the parser's request and result channels. Each accepted byte goes
// through a local model of the parse, and every result that comes out is
// compared field by field with the oldest predicted event.
// ----------------------------------------------------------------------------
module fmp_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  fmp_pkg::req_type req_data,
   input  logic             req_stall,
   input  logic             rsp_valid,
   input  fmp_pkg::rsp_type rsp_data,
   input  logic             rsp_stall,
   output int               fail_count,
   output int               events_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      P_SIG, P_HDR, P_SI, P_VLEN, P_VSTR, P_CCOUNT, P_CLEN, P_CSTR, P_SKIP, P_IDLE
   } phase_type;

   phase_type   phase;
   logic [23:0] byte_cnt;
   logic [63:0] gath;
   logic [6:0]  cur_type;
   logic        cur_last;
   logic [23:0] body_left;
   logic [31:0] cmt_left;
   logic [31:0] cmt_num;
   logic [31:0] str_left;

   fmp_pkg::rsp_type byte_events[3];
   int               n_events;
   fmp_pkg::rsp_type event_q[$];

   assign events_pending = event_q.size();

   function automatic void clear_parse();
      phase = P_SIG;
      byte_cnt = '0;
      gath = '0;
      cur_type = '0;
      cur_last = 1'b0;
      body_left = '0;
      cmt_left = '0;
      cmt_num = '0;
      str_left = '0;
   endfunction

   function automatic void post(logic [3:0] ev, logic [3:0] fld, logic [31:0] item,
                                logic [35:0] val);
      fmp_pkg::rsp_type r;
      if (n_events < 3) begin
         r.event_res = ev;
         r.block_type = cur_type;
         r.is_last_block = cur_last;
         r.field_index = fld;
         r.item_index = item;
         r.value = val;
         r.last_of_run = 1'b0;
         byte_events[n_events] = r;
         n_events++;
      end
   endfunction

   function automatic void new_header();
      phase = P_HDR;
      byte_cnt = '0;
      gath = '0;
   endfunction

   function automatic void close_block();
      if (cur_last) begin
         post(fmp_pkg::EV_END, 4'd0, 32'd0, 36'd0);
         phase = P_IDLE;
      end else begin
         new_header();
      end
   endfunction

   function automatic void next_comment();
      cmt_num++;
      cmt_left--;
      phase = (cmt_left != 0) ? P_CLEN : P_SKIP;
   endfunction

   // little-endian word gather; true once four bytes are in
   function automatic bit take_le(logic [7:0] b);
      gath |= 64'(b) << (8 * byte_cnt[1:0]);
      byte_cnt = (byte_cnt + 24'd1) & 24'd3;
      return byte_cnt == 0;
   endfunction

   function automatic void sinfo_byte(logic [7:0] b);
      gath = {gath[55:0], b};
      byte_cnt++;
      case (byte_cnt)
         24'd2:  post(fmp_pkg::EV_SINFO, 4'd0, 32'd0, 36'(gath[15:0]));
         24'd4:  post(fmp_pkg::EV_SINFO, 4'd1, 32'd0, 36'(gath[15:0]));
         24'd7:  post(fmp_pkg::EV_SINFO, 4'd2, 32'd0, 36'(gath[23:0]));
         24'd10: post(fmp_pkg::EV_SINFO, 4'd3, 32'd0, 36'(gath[23:0]));
         24'd13: begin
            post(fmp_pkg::EV_SINFO, 4'd4, 32'd0, 36'(gath[23:4]));
            post(fmp_pkg::EV_SINFO, 4'd5, 32'd0, 36'(gath[3:1]) + 36'd1);
         end
         24'd14: post(fmp_pkg::EV_SINFO, 4'd6, 32'd0, 36'(gath[8:4]) + 36'd1);
         24'd18: post(fmp_pkg::EV_SINFO, 4'd7, 32'd0, gath[35:0]);
         24'd22: post(fmp_pkg::EV_SINFO, 4'd8, 32'd0, 36'(gath[31:0]));
         24'd26: post(fmp_pkg::EV_SINFO, 4'd9, 32'd0, 36'(gath[31:0]));
         24'd30: post(fmp_pkg::EV_SINFO, 4'd10, 32'd0, 36'(gath[31:0]));
         24'd34: begin
            post(fmp_pkg::EV_SINFO, 4'd11, 32'd0, 36'(gath[31:0]));
            phase = P_SKIP;
         end
         default: ;
      endcase
   endfunction

   function automatic void parse_byte(fmp_pkg::req_type rq);
      logic [7:0] b;
      b = rq.data_byte;
      n_events = 0;
      if (rq.start_of_file) clear_parse();
      case (phase)
         P_SIG: begin
            gath = {32'd0, gath[23:0], b};
            byte_cnt++;
            if (byte_cnt >= 4) begin
               if (gath[31:0] != fmp_pkg::FLAC_SIG) begin
                  post(fmp_pkg::EV_BADSIG, 4'd0, 32'd0, 36'd0);
                  phase = P_IDLE;
               end else begin
                  new_header();
               end
            end
         end
         P_HDR: begin
            gath = {32'd0, gath[23:0], b};
            byte_cnt++;
            if (byte_cnt >= 4) begin
               cur_last = gath[31];
               cur_type = gath[30:24];
               body_left = gath[23:0];
               post(fmp_pkg::EV_HEADER, 4'd0, 32'd0, 36'(body_left));
               byte_cnt = '0;
               gath = '0;
               if (cur_type == fmp_pkg::TYPE_SINFO) phase = P_SI;
               else if (cur_type == fmp_pkg::TYPE_VORBIS) phase = P_VLEN;
               else phase = P_SKIP;
               if (body_left == 0) close_block();
            end
         end
         P_IDLE: ;
         default: begin
            case (phase)
               P_SI: sinfo_byte(b);
               P_VLEN: if (take_le(b)) begin
                  str_left = gath[31:0];
                  gath = '0;
                  post(fmp_pkg::EV_VLEN, 4'd0, 32'd0, 36'(str_left));
                  phase = (str_left != 0) ? P_VSTR : P_CCOUNT;
               end
               P_VSTR: begin
                  post(fmp_pkg::EV_VBYTE, 4'd0, 32'd0, 36'(b));
                  str_left--;
                  if (str_left == 0) phase = P_CCOUNT;
               end
               P_CCOUNT: if (take_le(b)) begin
                  cmt_left = gath[31:0];
                  gath = '0;
                  cmt_num = '0;
                  post(fmp_pkg::EV_CCOUNT, 4'd0, 32'd0, 36'(cmt_left));
                  phase = (cmt_left != 0) ? P_CLEN : P_SKIP;
               end
               P_CLEN: if (take_le(b)) begin
                  str_left = gath[31:0];
                  gath = '0;
                  post(fmp_pkg::EV_CLEN, 4'd0, cmt_num, 36'(str_left));
                  if (str_left == 0) next_comment();
                  else phase = P_CSTR;
               end
               P_CSTR: begin
                  post(fmp_pkg::EV_CBYTE, 4'd0, cmt_num, 36'(b));
                  str_left--;
                  if (str_left == 0) next_comment();
               end
               default: ;
            endcase
            body_left = body_left - 24'd1;
            if (body_left == 0) close_block();
         end
      endcase
      if (n_events > 0) byte_events[n_events-1].last_of_run = 1'b1;
      for (int i = 0; i < n_events; i++) event_q = {event_q, byte_events[i]};
   endfunction

   always @(posedge clock) begin
      fmp_pkg::rsp_type want;
      if (reset) begin
         clear_parse();
         event_q.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) parse_byte(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (event_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = event_q.pop_front();
               if (rsp_data !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the metadata parser bench. Builds byte streams of whole files
// (signature, header, STREAMINFO, comment and other blocks, with
// exact, short and padded lengths, bad signatures and restarts), feeds them
// in bursts against a stalling receiver, and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock;
   logic             reset;
   logic             req_valid;
   fmp_pkg::req_type req_data;
   logic             req_stall;
   logic             rsp_valid;
   fmp_pkg::rsp_type rsp_data;
   logic             rsp_stall;
   int               fail_count;
   int               events_pending;

   fmp_pkg::req_type stim_q[$];
   int      req_idx;
   int      burst_left;
   int      gap_left;
   int      stall_mode;
   int      stall_cnt;
   int      idle_cycles;

   flac_metadata_parser u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall)
   );

   fmp_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall),
      .fail_count(fail_count), .events_pending(events_pending)
   );

   function automatic void put(logic [7:0] b, bit sof);
      fmp_pkg::req_type r;
      r.data_byte = b;
      r.start_of_file = sof;
      stim_q = {stim_q, r};
   endfunction

   function automatic void push_le(ref logic [7:0] body[$], input logic [31:0] w);
      for (int i = 0; i < 4; i++) body = {body, w[8*i +: 8]};
   endfunction

   function automatic void add_sig(bit sof, bit bad);
      logic [31:0] w;
      w = fmp_pkg::FLAC_SIG;
      if (bad) w ^= 32'd1 << $urandom_range(31);
      for (int i = 3; i >= 0; i--) put(w[8*i +: 8], sof && i == 3);
   endfunction

   // header with the declared length, then that many body bytes (random past
   // the built body), capped at four bytes past the body for longer lengths
   function automatic void add_block(bit last, logic [6:0] btype, logic [7:0] body[$],
                                     logic [23:0] declared);
      int n;
      put({last, btype}, 1'b0);
      put(declared[23:16], 1'b0);
      put(declared[15:8], 1'b0);
      put(declared[7:0], 1'b0);
      n = (declared > body.size() + 4) ? body.size() + 4 : int'(declared);
      for (int i = 0; i < n; i++) put(i < body.size() ? body[i] : 8'($urandom), 1'b0);
   endfunction

   function automatic void vorbis_body(ref logic [7:0] body[$], input bit garbage);
      int vl;
      int nc;
      int cl;
      vl = $urandom_range(3);
      push_le(body, 32'(vl));
      for (int i = 0; i < vl; i++) body = {body, 8'($urandom)};
      nc = $urandom_range(3);
      push_le(body, garbage ? 32'($urandom) : 32'(nc));
      for (int c = 0; c < nc; c++) begin
         cl = $urandom_range(3);
         push_le(body, 32'(cl));
         for (int i = 0; i < cl; i++) body = {body, 8'($urandom)};
      end
   endfunction

   function automatic void random_file(bit sof);
      logic [7:0]  body[$];
      logic [6:0]  btype;
      logic [23:0] declared;
      int          nblk;
      int          pick;
      bit          last;
      add_sig(sof, $urandom_range(9) == 0);
      nblk = $urandom_range(1, 3);
      for (int k = 0; k < nblk; k++) begin
         body.delete();
         last = (k == nblk - 1);
         pick = $urandom_range(99);
         if (pick < 40) begin
            btype = fmp_pkg::TYPE_SINFO;
            for (int i = 0; i < 34; i++) body = {body, 8'($urandom)};
         end else if (pick < 75) begin
            btype = fmp_pkg::TYPE_VORBIS;
            vorbis_body(body, $urandom_range(7) == 0);
         end else begin
            btype = 7'($urandom);
            for (int i = $urandom_range(5); i > 0; i--) body = {body, 8'($urandom)};
         end
         pick = $urandom_range(99);
         if (pick < 70) declared = 24'(body.size());
         else if (pick < 82) declared = 24'(body.size() + $urandom_range(1, 4));
         else if (pick < 94) declared = 24'($urandom_range(body.size()));
         else begin
            // huge length: the next file's start flag cuts it off
            declared = 24'($urandom) | 24'h800000;
            add_block(1'b0, btype, body, declared);
            return;
         end
         add_block(last, btype, body, declared);
      end
      if ($urandom_range(4) == 0)
         for (int i = $urandom_range(1, 3); i > 0; i--) put(8'($urandom), 1'b0);
   endfunction

   initial begin
      logic [7:0] body[$];
      // no start flag after reset; all-ones streaminfo, empty vorbis counts
      add_sig(1'b0, 1'b0);
      for (int i = 0; i < 34; i++) body = {body, 8'hFF};
      add_block(1'b0, fmp_pkg::TYPE_SINFO, body, 24'd34);
      body.delete();
      push_le(body, 32'd0);
      push_le(body, 32'd0);
      add_block(1'b0, fmp_pkg::TYPE_VORBIS, body, 24'd8);
      body.delete();
      add_block(1'b1, 7'h7F, body, 24'd0);
      put(8'hA5, 1'b0);
      add_sig(1'b1, 1'b1);
      put(8'h00, 1'b0);
      add_sig(1'b1, 1'b0);
      for (int i = 0; i < 34; i++) body = {body, 8'h00};
      add_block(1'b1, fmp_pkg::TYPE_SINFO, body, 24'd20);
      while (stim_q.size() < 200) random_file(1'b1);
   end

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         req_idx <= 0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (req_idx < stim_q.size()) begin
            req_valid <= 1'b1;
            req_data <= stim_q[req_idx];
            req_idx <= req_idx + 1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: modes of no stall, random stall and long stall runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt % 97 == 96) stall_mode <= $urandom_range(2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(1) == 0);
            default: rsp_stall <= (stall_cnt % 16) < 10;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      @(negedge reset);
      wait (req_idx == stim_q.size() && stim_q.size() > 0 && !req_valid);
      wait (events_pending == 0);
      repeat (30) @(posedge clock);
      if (fail_count == 0 && events_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
